[sv/tolp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tolp_pkg;

    localparam int FRAC_BITS       = 4;
    localparam int MAX_FRAC_DIGITS = 4;
    localparam int OFFSET_W        = 16;
    localparam int INT_W           = OFFSET_W - FRAC_BITS;
    localparam int INT_CAP         = 1 << (OFFSET_W - 1 - FRAC_BITS);
    localparam int FRAC_SCALE      = 10 ** MAX_FRAC_DIGITS;
    localparam int FRAC_W          = (MAX_FRAC_DIGITS == 0) ? 1 : $clog2(FRAC_SCALE);
    localparam int FDIG_W          = (MAX_FRAC_DIGITS == 0) ? 1 : $clog2(MAX_FRAC_DIGITS + 1);

    localparam int STATE_W = 3;
    localparam logic [STATE_W-1:0] STATE_MAX = 3'd3;
    localparam logic [STATE_W-1:0] STATE_BAD = 3'd4;

    localparam int FIELD_W = 2;
    localparam logic [FIELD_W-1:0] FIELD_X     = 2'd0;
    localparam logic [FIELD_W-1:0] FIELD_Y     = 2'd1;
    localparam logic [FIELD_W-1:0] FIELD_STATE = 2'd2;
    localparam logic [FIELD_W-1:0] FIELD_SKIP  = 2'd3;
    localparam logic [FIELD_W-1:0] COUNT_ONE   = 2'd1;
    localparam logic [FIELD_W-1:0] COUNT_MAX   = 2'd3;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        PH_LEAD   = 3'd0,
        PH_SIGN   = 3'd1,
        PH_INT    = 3'd2,
        PH_DOT0   = 3'd3,
        PH_FRACI  = 3'd4,
        PH_FRACN  = 3'd5,
        PH_TAILOK = 3'd6,
        PH_TAILX  = 3'd7
    } phase_t;

    typedef struct packed {
        logic scan;
        logic clear;
    } num_ctrl_t;

    typedef struct packed {
        logic                float_ok;
        logic                int_ok;
        logic [OFFSET_W-1:0] fixed;
        logic [STATE_W-1:0]  state;
    } num_status_t;

endpackage

`default_nettype wire

[sv/tolp_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface tolp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       line_end;

    modport source (output valid, output ch, output line_end, input ready);
    modport sink (input valid, input ch, input line_end, output ready);
endinterface

`default_nettype wire

[sv/tolp_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface tolp_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] aim_x;
    logic signed [15:0] aim_y;
    logic [1:0]         track_code;

    modport source (output valid, output aim_x, output aim_y, output track_code,
                    input ready);
    modport sink (input valid, input aim_x, input aim_y, input track_code,
                  output ready);
endinterface

`default_nettype wire

[sv/tolp_num_scan.sv]
`timescale 1ns / 1ps
`default_nettype none

module tolp_num_scan
    import tolp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire num_ctrl_t   ctrl,
    input  wire logic [7:0]  ch,
    output num_status_t      status
);

    localparam int PROD_W = FRAC_W + FRAC_BITS;
    localparam int SUM_W  = INT_W + 4;
    localparam logic [OFFSET_W-1:0] MAG_POS_LIMIT = {1'b0, {(OFFSET_W-1){1'b1}}};
    localparam logic [OFFSET_W-1:0] MAG_NEG_LIMIT = {1'b1, {(OFFSET_W-1){1'b0}}};

    phase_t              phase_reg, phase_next;
    logic                neg_reg, neg_next;
    logic [INT_W-1:0]    int_reg, int_next;
    logic [FRAC_W-1:0]   frac_reg, frac_next;
    logic [FDIG_W-1:0]   fdig_reg, fdig_next;

    logic                is_digit;
    logic                is_space;
    logic [3:0]          digit;
    logic [SUM_W-1:0]    int_wide;
    logic [INT_W-1:0]    int_add;
    logic [FRAC_W-1:0]   weight;
    logic [FRAC_W-1:0]   frac_add;
    logic                frac_room;
    logic [PROD_W-1:0]   frac_shift;
    logic [FRAC_BITS-1:0] frac_q;
    logic [OFFSET_W-1:0] mag;

    always_comb
    begin
        is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
        is_space = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
        digit    = ch[3:0];

        int_wide = SUM_W'(int_reg) * SUM_W'(10) + SUM_W'(digit);
        int_add  = (int_wide > SUM_W'(INT_CAP)) ? INT_W'(INT_CAP) : int_wide[INT_W-1:0];

        // Each fraction digit is weighted by its place, so the register always
        // holds the fraction scaled to the full digit count.
        weight = '0;
        for (int i = 0; i < MAX_FRAC_DIGITS; i++)
        begin
            if (fdig_reg == FDIG_W'(i))
            begin
                weight = FRAC_W'(10 ** (MAX_FRAC_DIGITS - 1 - i));
            end
        end
        frac_room = fdig_reg < FDIG_W'(MAX_FRAC_DIGITS);
        frac_add  = frac_reg + FRAC_W'(weight * FRAC_W'(digit));
    end

    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        int_next   = int_reg;
        frac_next  = frac_reg;
        fdig_next  = fdig_reg;
        if (ctrl.clear)
        begin
            phase_next = PH_LEAD;
            neg_next   = 1'b0;
            int_next   = '0;
            frac_next  = '0;
            fdig_next  = '0;
        end
        else if (ctrl.scan)
        begin
            unique case (phase_reg)
                PH_LEAD:
                begin
                    if (is_space)
                    begin
                        phase_next = PH_LEAD;
                    end
                    else if ((ch == CH_PLUS) || (ch == CH_MINUS))
                    begin
                        neg_next   = (ch == CH_MINUS);
                        phase_next = PH_SIGN;
                    end
                    else if (is_digit)
                    begin
                        int_next   = int_add;
                        phase_next = PH_INT;
                    end
                    else if (ch == CH_DOT)
                    begin
                        phase_next = PH_DOT0;
                    end
                    else
                    begin
                        phase_next = PH_TAILX;
                    end
                end
                PH_SIGN:
                begin
                    if (is_digit)
                    begin
                        int_next   = int_add;
                        phase_next = PH_INT;
                    end
                    else if (ch == CH_DOT)
                    begin
                        phase_next = PH_DOT0;
                    end
                    else
                    begin
                        phase_next = PH_TAILX;
                    end
                end
                PH_INT:
                begin
                    if (is_digit)
                    begin
                        int_next = int_add;
                    end
                    else if (ch == CH_DOT)
                    begin
                        phase_next = PH_FRACI;
                    end
                    else
                    begin
                        phase_next = PH_TAILOK;
                    end
                end
                PH_DOT0, PH_FRACI, PH_FRACN:
                begin
                    if (is_digit)
                    begin
                        if (frac_room)
                        begin
                            frac_next = frac_add;
                            fdig_next = fdig_reg + FDIG_W'(1);
                        end
                        if (phase_reg == PH_DOT0)
                        begin
                            phase_next = PH_FRACN;
                        end
                    end
                    else if (phase_reg == PH_FRACI)
                    begin
                        phase_next = PH_TAILOK;
                    end
                    else
                    begin
                        phase_next = PH_TAILX;
                    end
                end
                PH_TAILOK, PH_TAILX:
                begin
                    phase_next = phase_reg;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        status.float_ok = (phase_reg == PH_INT) || (phase_reg == PH_FRACI) ||
                          (phase_reg == PH_FRACN);
        status.int_ok   = (phase_reg == PH_INT) || (phase_reg == PH_FRACI) ||
                          (phase_reg == PH_TAILOK);

        // The fraction part of the offset is the largest step count whose
        // threshold the scaled fraction reaches, truncating toward zero.
        frac_shift = PROD_W'(frac_reg) << FRAC_BITS;
        frac_q     = '0;
        for (int j = 1; j < (1 << FRAC_BITS); j++)
        begin
            if (frac_shift >= PROD_W'(j * FRAC_SCALE))
            begin
                frac_q = FRAC_BITS'(j);
            end
        end
        mag = {int_reg, {FRAC_BITS{1'b0}}} + OFFSET_W'(frac_q);

        if (neg_reg)
        begin
            status.fixed = ~((mag > MAG_NEG_LIMIT) ? MAG_NEG_LIMIT : mag) + OFFSET_W'(1);
        end
        else
        begin
            status.fixed = (mag > MAG_POS_LIMIT) ? MAG_POS_LIMIT : mag;
        end

        if ((neg_reg && (int_reg != '0)) || (int_reg > INT_W'(STATE_MAX)))
        begin
            status.state = STATE_BAD;
        end
        else
        begin
            status.state = STATE_W'(int_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEAD;
            neg_reg   <= 1'b0;
            int_reg   <= '0;
            frac_reg  <= '0;
            fdig_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            int_reg   <= int_next;
            frac_reg  <= frac_next;
            fdig_reg  <= fdig_next;
        end
    end

endmodule

`default_nettype wire

[sv/target_offset_line_parser.sv]
`timescale 1ns / 1ps
`default_nettype none
// Result path: an accepted line_end request is held in the input register, then
// its result is loaded into the result register once that register is free.
// Throughput: one request per cycle; only a line_end request waits, and only
// while the previous result is still held in the result register.
// Reset: rst_n clears the line and number state and the held offsets at once.

module target_offset_line_parser
    import tolp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    tolp_in_if.sink      chars,
    tolp_out_if.source   result
);

    logic                in_vld_reg;
    logic [7:0]          ch_reg;
    logic                end_reg;

    logic [FIELD_W-1:0]  field_reg, field_next;
    logic [FIELD_W-1:0]  count_reg, count_next;
    logic                bad_reg, bad_next;
    logic                nonempty_reg, nonempty_next;
    logic                prev_comma_reg, prev_comma_next;
    logic [OFFSET_W-1:0] held_x_reg, held_x_next;
    logic [OFFSET_W-1:0] held_y_reg, held_y_next;
    logic [STATE_W-1:0]  held_state_reg, held_state_next;

    logic                out_vld_reg;
    logic [OFFSET_W-1:0] out_x_reg;
    logic [OFFSET_W-1:0] out_y_reg;
    logic [1:0]          out_state_reg;

    logic                advance;
    logic                is_comma;
    logic                need_state;
    logic                end_bad;
    logic                emit;
    logic [STATE_W-1:0]  end_state;
    num_ctrl_t           scan_ctrl;
    num_status_t         scan_status;

    tolp_num_scan u_num_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (scan_ctrl),
        .ch     (ch_reg),
        .status (scan_status)
    );

    assign advance      = in_vld_reg && !(end_reg && out_vld_reg && !result.ready);
    assign chars.ready  = !in_vld_reg || advance;
    assign is_comma     = (ch_reg == CH_COMMA);

    assign scan_ctrl = '{
        scan:  advance && !end_reg && !is_comma && (field_reg != FIELD_SKIP),
        clear: advance && (end_reg || is_comma)
    };

    always_comb
    begin
        need_state = (count_reg == COUNT_ONE) || (field_reg == FIELD_STATE);
        end_state  = (need_state && scan_status.int_ok) ? scan_status.state : held_state_reg;
        end_bad    = bad_reg || prev_comma_reg || (count_reg == '0) ||
                     (need_state && !scan_status.int_ok) || (end_state > STATE_MAX);
        emit       = advance && end_reg && nonempty_reg && !end_bad;
    end

    always_comb
    begin
        field_next      = field_reg;
        count_next      = count_reg;
        bad_next        = bad_reg;
        nonempty_next   = nonempty_reg;
        prev_comma_next = prev_comma_reg;
        held_x_next     = held_x_reg;
        held_y_next     = held_y_reg;
        held_state_next = held_state_reg;
        if (advance && !end_reg)
        begin
            if (is_comma)
            begin
                if (!nonempty_reg || prev_comma_reg)
                begin
                    bad_next = 1'b1;
                end
                unique case (field_reg)
                    FIELD_X:
                    begin
                        if (scan_status.float_ok)
                        begin
                            held_x_next = scan_status.fixed;
                        end
                        else
                        begin
                            bad_next = 1'b1;
                        end
                    end
                    FIELD_Y:
                    begin
                        if (scan_status.float_ok)
                        begin
                            held_y_next = scan_status.fixed;
                        end
                        else
                        begin
                            bad_next = 1'b1;
                        end
                    end
                    FIELD_STATE:
                    begin
                        if (scan_status.int_ok)
                        begin
                            held_state_next = scan_status.state;
                        end
                        else
                        begin
                            bad_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        bad_next = bad_next;
                    end
                endcase
                if (field_reg != FIELD_SKIP)
                begin
                    field_next = field_reg + FIELD_W'(1);
                end
                if (count_reg != COUNT_MAX)
                begin
                    count_next = count_reg + FIELD_W'(1);
                end
                prev_comma_next = 1'b1;
            end
            else
            begin
                prev_comma_next = 1'b0;
            end
            nonempty_next = 1'b1;
        end
        else if (advance && end_reg)
        begin
            if (nonempty_reg)
            begin
                held_state_next = end_state;
                if (count_reg == COUNT_ONE)
                begin
                    held_y_next = '0;
                end
            end
            field_next      = FIELD_X;
            count_next      = '0;
            bad_next        = 1'b0;
            nonempty_next   = 1'b0;
            prev_comma_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg     <= 1'b0;
            field_reg      <= FIELD_X;
            count_reg      <= '0;
            bad_reg        <= 1'b0;
            nonempty_reg   <= 1'b0;
            prev_comma_reg <= 1'b0;
            held_x_reg     <= '0;
            held_y_reg     <= '0;
            held_state_reg <= '0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            if (chars.ready)
            begin
                in_vld_reg <= chars.valid;
            end
            field_reg      <= field_next;
            count_reg      <= count_next;
            bad_reg        <= bad_next;
            nonempty_reg   <= nonempty_next;
            prev_comma_reg <= prev_comma_next;
            held_x_reg     <= held_x_next;
            held_y_reg     <= held_y_next;
            held_state_reg <= held_state_next;
            if (emit)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            ch_reg  <= chars.ch;
            end_reg <= chars.line_end;
        end
        if (emit)
        begin
            out_x_reg     <= held_x_reg;
            out_y_reg     <= (count_reg == COUNT_ONE) ? '0 : held_y_reg;
            out_state_reg <= end_state[1:0];
        end
    end

    assign result.valid      = out_vld_reg;
    assign result.aim_x      = out_x_reg;
    assign result.aim_y      = out_y_reg;
    assign result.track_code = out_state_reg;

`ifndef ASSERT_OFF
    a_count_tracks_field: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == field_reg)
        else $error("comma count and field index disagree");

    a_line_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        advance && end_reg |=> !nonempty_reg && (count_reg == '0) && !bad_reg)
        else $error("line state not cleared after line end");

    a_result_from_line_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !$past(out_vld_reg) |-> $past(advance && end_reg))
        else $error("result appeared without a line end request");

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && !advance |-> !chars.ready)
        else $error("new request taken while input register is blocked");
`endif

endmodule

`default_nettype wire
